@@ src/twt_pkg.sv @@
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types, byte codes and the character classifier of the text word
// tokenizer.
// ----------------------------------------------------------------------------
package twt_pkg;

	localparam int WORD_BUFFER_DEF = 32;
	localparam int DESC_DEPTH      = 4;
	localparam int CHAR_W          = 8;
	localparam int IDX_W           = 5;
	localparam int NUM_W           = 16;
	localparam int IN_TDATA_W      = 8;
	localparam int OUT_TDATA_W     = 32;
	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	// Byte codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_EXCL   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Scanner states
	typedef enum logic [4:0] {
		MODE_DETECT = 5'b00001,
		MODE_SKIP   = 5'b00010,
		MODE_TAG    = 5'b00100,
		MODE_QUOTE  = 5'b01000,
		MODE_WORD   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic white;
		logic punct;
		logic delim;
	} char_class_t;

	// Queue fill status seen by the front end
	typedef struct packed {
		logic ring_full;
		logic desc_full;
	} q_status_t;

	// Read control from the emitter to the queue
	typedef struct packed {
		logic issue;
		logic done;
	} rd_ctrl_t;

	function automatic char_class_t classify(input logic [7:0] b);
		char_class_t c;
		c = '0;
		unique case (b) inside
			CH_SPACE, CH_TAB, CH_NL: begin
				c = '{white: 1'b1, punct: 1'b0, delim: 1'b1};
			end
			CH_DASH: begin
				c = '{white: 1'b0, punct: 1'b1, delim: 1'b0};
			end
			CH_DOT, CH_COMMA, CH_QMARK, CH_COLON, CH_SEMI, CH_EXCL, CH_LT, CH_GT,
			CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_LBRK, CH_RBRK, CH_PLUS,
			CH_AMP, CH_APOS, CH_QUOTE, CH_SLASH: begin
				c = '{white: 1'b0, punct: 1'b1, delim: 1'b1};
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

endpackage

@@ src/twt_front.sv @@
// ----------------------------------------------------------------------------
// twt_front
// Byte scanner: classifies each input byte, tracks tags and quotes, writes
// word characters to the character ring and pushes one descriptor per word.
// ----------------------------------------------------------------------------
module twt_front #(
	parameter int WORD_BUFFER = twt_pkg::WORD_BUFFER_DEF,
	parameter int LEN_W       = $clog2(WORD_BUFFER)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [twt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] byte_value
	input  logic                              s_axis_tlast,  // end_of_stream
	input  twt_pkg::q_status_t                status,
	output logic                              wr_en,
	output logic [twt_pkg::CHAR_W-1:0]        wr_data,
	output logic                              push,
	output logic [twt_pkg::NUM_W+2*LEN_W-1:0] push_desc      // {number, total, kept}
);
	import twt_pkg::*;

	localparam int WORD_LIMIT = WORD_BUFFER - 1;

	mode_t             mode_q, mode_eff, mode_nx;
	logic              html_q, html_eff;
	logic [LEN_W-1:0]  fill_q, kept_fill_q;
	logic [LEN_W-1:0]  fill_after, kept_after;
	logic [NUM_W-1:0]  counter_q;
	char_class_t       cls;
	logic              detect_exit, store, flush, accept;
	logic [7:0]        byte_in;

	assign byte_in       = s_axis_tdata[7:0];
	assign s_axis_tready = !status.ring_full && !status.desc_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Scan one byte: next mode, store and flush decisions
	always_comb begin
		cls         = classify(byte_in);
		detect_exit = (mode_q == MODE_DETECT) && !cls.white;
		mode_eff    = detect_exit ? MODE_SKIP : mode_q;
		html_eff    = detect_exit ? (byte_in == CH_LT) : html_q;
		mode_nx     = mode_eff;
		store       = 1'b0;
		flush       = 1'b0;
		fill_after  = fill_q;
		kept_after  = kept_fill_q;
		unique case (mode_eff)
			MODE_SKIP: begin
				if (html_eff && byte_in == CH_LT) begin
					mode_nx = MODE_TAG;
				end else if (!(cls.white || cls.punct)) begin
					store      = 1'b1;
					fill_after = LEN_W'(1);
					kept_after = LEN_W'(1);
					if (fill_after >= LEN_W'(WORD_LIMIT)) begin
						flush = 1'b1;
					end else begin
						mode_nx = MODE_WORD;
					end
				end
			end
			MODE_TAG: begin
				if (byte_in == CH_GT) begin
					mode_nx = MODE_SKIP;
				end else if (byte_in == CH_QUOTE) begin
					mode_nx = MODE_QUOTE;
				end
			end
			MODE_QUOTE: begin
				if (byte_in == CH_QUOTE) begin
					mode_nx = MODE_TAG;
				end
			end
			MODE_WORD: begin
				if (cls.white || cls.delim) begin
					flush   = 1'b1;
					mode_nx = MODE_SKIP;
				end else begin
					store      = 1'b1;
					fill_after = fill_q + LEN_W'(1);
					if (!cls.punct) begin
						kept_after = fill_after;
					end
					if (fill_after >= LEN_W'(WORD_LIMIT)) begin
						flush   = 1'b1;
						mode_nx = MODE_SKIP;
					end
				end
			end
			MODE_DETECT: begin
				mode_nx = MODE_DETECT;
			end
			default: begin
				mode_nx = MODE_DETECT;
			end
		endcase
		// End of record flushes a word still open
		if (s_axis_tlast && mode_nx == MODE_WORD && !flush) begin
			flush = 1'b1;
		end
	end

	assign wr_en     = accept && store;
	assign wr_data   = byte_in;
	assign push      = accept && flush;
	assign push_desc = {counter_q, fill_after, kept_after};

	// Advance scanner state on each transaction; end of record resets it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DETECT;
			html_q      <= 1'b0;
			fill_q      <= '0;
			kept_fill_q <= '0;
			counter_q   <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				mode_q      <= MODE_DETECT;
				html_q      <= 1'b0;
				fill_q      <= '0;
				kept_fill_q <= '0;
				counter_q   <= '0;
			end else begin
				mode_q      <= mode_nx;
				html_q      <= html_eff;
				fill_q      <= flush ? '0 : fill_after;
				kept_fill_q <= flush ? '0 : kept_after;
				if (flush && counter_q != NUM_MAX) begin
					counter_q <= counter_q + NUM_W'(1);
				end
			end
		end
	end

	a_fill_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < LEN_W'(WORD_LIMIT))
		else $error("word fill reached the store limit");

	a_word_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_WORD |-> (fill_q != '0 && kept_fill_q != '0))
		else $error("word mode with no leading character");

	a_desc_sane: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (kept_after != '0 && kept_after <= fill_after))
		else $error("word descriptor with bad trimmed length");

endmodule

@@ src/twt_queue.sv @@
// ----------------------------------------------------------------------------
// twt_queue
// Decoupling queue: a character ring memory holding finished and pending
// word characters, plus a short descriptor queue with one entry per word.
// ----------------------------------------------------------------------------
module twt_queue #(
	parameter int LEN_W   = 5,
	parameter int RING_AW = LEN_W + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [twt_pkg::CHAR_W-1:0]        wr_data,
	input  logic                              push,
	input  logic [twt_pkg::NUM_W+2*LEN_W-1:0] push_desc,
	output twt_pkg::q_status_t                status,
	output logic                              head_valid,
	output logic [twt_pkg::NUM_W+2*LEN_W-1:0] head_desc,
	input  twt_pkg::rd_ctrl_t                 rd_ctrl,
	input  logic [LEN_W-1:0]                  rd_offset,
	output logic [twt_pkg::CHAR_W-1:0]        rd_data
);
	import twt_pkg::*;

	localparam int RING_DEPTH = 2 ** RING_AW;
	localparam int DESC_AW    = $clog2(DESC_DEPTH);
	localparam int DESC_W     = NUM_W + 2 * LEN_W;

	logic [CHAR_W-1:0]  ring_mem [RING_DEPTH];
	logic [CHAR_W-1:0]  rd_data_q;
	logic [RING_AW:0]   wptr_q, rptr_q, ring_used;
	logic [RING_AW-1:0] rd_addr;
	logic [DESC_W-1:0]  desc_mem [DESC_DEPTH];
	logic [DESC_AW:0]   dw_q, dr_q, desc_used;
	logic [LEN_W-1:0]   head_total;

	assign ring_used        = wptr_q - rptr_q;
	assign desc_used        = dw_q - dr_q;
	assign status.ring_full = ring_used == (RING_AW + 1)'(RING_DEPTH);
	assign status.desc_full = desc_used == (DESC_AW + 1)'(DESC_DEPTH);
	assign head_valid       = dw_q != dr_q;
	assign head_desc        = desc_mem[dr_q[DESC_AW-1:0]];
	assign head_total       = head_desc[2*LEN_W-1:LEN_W];
	assign rd_addr          = rptr_q[RING_AW-1:0] + RING_AW'(rd_offset);
	assign rd_data          = rd_data_q;

	// Character ring: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wptr_q[RING_AW-1:0]] <= wr_data;
		end
		if (rd_ctrl.issue) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// Descriptor storage
	always_ff @(posedge clk) begin
		if (push) begin
			desc_mem[dw_q[DESC_AW-1:0]] <= push_desc;
		end
	end

	// Pointers: release the whole word, trimmed tail included, when it is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			dw_q   <= '0;
			dr_q   <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + (RING_AW + 1)'(1);
			end
			if (push) begin
				dw_q <= dw_q + (DESC_AW + 1)'(1);
			end
			if (rd_ctrl.done) begin
				dr_q   <= dr_q + (DESC_AW + 1)'(1);
				rptr_q <= rptr_q + (RING_AW + 1)'(head_total);
			end
		end
	end

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_used <= (RING_AW + 1)'(RING_DEPTH))
		else $error("character ring overrun");

	a_desc_order: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.desc_full) && !(rd_ctrl.done && !head_valid))
		else $error("descriptor queue overflow or underflow");

endmodule

@@ src/twt_back.sv @@
// ----------------------------------------------------------------------------
// twt_back
// Word emitter: walks the head word in the ring one character per cycle when
// not stalled, driving the stream through a read stage and an output register.
// ----------------------------------------------------------------------------
module twt_back #(
	parameter int LEN_W = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  logic [twt_pkg::NUM_W+2*LEN_W-1:0] head_desc,
	output twt_pkg::rd_ctrl_t                 rd_ctrl,
	output logic [LEN_W-1:0]                  rd_offset,
	input  logic [twt_pkg::CHAR_W-1:0]        rd_data,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [twt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [7:0] char_value,
	                                                         // [12:8] char_index,
	                                                         // [28:13] word_number
	output logic                              m_axis_tlast   // end_of_word
);
	import twt_pkg::*;

	localparam int DESC_W = NUM_W + 2 * LEN_W;

	logic [LEN_W-1:0]  k_q, kept;
	logic [NUM_W-1:0]  num;
	logic              out_free, issue, last_k;
	logic              valid_s1, last_s1;
	logic [LEN_W-1:0]  idx_s1;
	logic [NUM_W-1:0]  num_s1;
	logic              out_valid_q, out_last_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [NUM_W-1:0]  out_num_q;

	assign kept     = head_desc[LEN_W-1:0];
	assign num      = head_desc[DESC_W-1 -: NUM_W];
	assign out_free = !out_valid_q || m_axis_tready;
	assign issue    = head_valid && (!valid_s1 || out_free);
	assign last_k   = k_q == (kept - LEN_W'(1));

	assign rd_ctrl.issue = issue;
	assign rd_ctrl.done  = issue && last_k;
	assign rd_offset     = k_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_num_q, out_idx_q, out_char_q};

	// Character counter within the head word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= last_k ? '0 : k_q + LEN_W'(1);
		end
	end

	// Read stage and output register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload: hold while stalled
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= k_q;
			num_s1  <= num;
			last_s1 <= last_k;
		end
		if (out_free && valid_s1) begin
			out_char_q <= rd_data;
			out_idx_q  <= IDX_W'(idx_s1);
			out_num_q  <= num_s1;
			out_last_q <= last_s1;
		end
	end

	a_counter_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ctrl.done |=> k_q == '0)
		else $error("character counter not cleared after word end");

endmodule

@@ src/text_word_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// text_word_tokenizer_top
// Splits a text record, one byte per transaction, into words and emits each
// word one character per transaction with its index and word number.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the record: tdata[7:0] is the byte, tlast marks the last
//   byte of the record. m_axis carries one character per transaction:
//   tdata[7:0] character, [12:8] index in the word, [28:13] word number
//   (saturating), tlast on the last character of the word.
//   The scanner takes one byte per cycle. It stalls only when the character
//   ring (2 * 2**clog2(WORD_BUFFER) bytes) or the four-entry word queue is
//   full. The emitter sends one character per cycle while m_axis_tready is
//   high. The first character of a word is presented on m_axis once its
//   descriptor has passed the word queue, the read stage and the output
//   register, if the emitter is idle.
//   A stall on m_axis backs up the output register, the read stage and the
//   queue; the scanner keeps taking bytes until the queue fills.
//   Reset empties the queues and returns the scanner to its start state; no
//   memory clearing pass is needed. tlast on the input flushes any open word
//   and restarts the scanner and word numbering for the next record.
// ----------------------------------------------------------------------------
module text_word_tokenizer_top #(
	parameter int WORD_BUFFER = twt_pkg::WORD_BUFFER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [twt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] byte_value
	input  logic                            s_axis_tlast,  // end_of_stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [twt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] char_value,
	                                                       // [12:8] char_index,
	                                                       // [28:13] word_number
	output logic                            m_axis_tlast   // end_of_word
);
	import twt_pkg::*;

	localparam int LEN_W   = $clog2(WORD_BUFFER);
	localparam int RING_AW = LEN_W + 1;
	localparam int DESC_W  = NUM_W + 2 * LEN_W;

	q_status_t         status;
	rd_ctrl_t          rd_ctrl;
	logic              wr_en, push, head_valid;
	logic [CHAR_W-1:0] wr_data, rd_data;
	logic [DESC_W-1:0] push_desc, head_desc;
	logic [LEN_W-1:0]  rd_offset;

	twt_front #(
		.WORD_BUFFER (WORD_BUFFER),
		.LEN_W       (LEN_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.status        (status),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.push          (push),
		.push_desc     (push_desc)
	);

	twt_queue #(
		.LEN_W   (LEN_W),
		.RING_AW (RING_AW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.push       (push),
		.push_desc  (push_desc),
		.status     (status),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.rd_ctrl    (rd_ctrl),
		.rd_offset  (rd_offset),
		.rd_data    (rd_data)
	);

	twt_back #(
		.LEN_W (LEN_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_desc     (head_desc),
		.rd_ctrl       (rd_ctrl),
		.rd_offset     (rd_offset),
		.rd_data       (rd_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ verif/text_word_tokenizer_top_test.sv @@
// ----------------------------------------------------------------------------
// text_word_tokenizer_top_test
// Self-checking bench for the text word tokenizer. A short table of records
// walks leading whitespace, plain and HTML modes, quoted tag content, trailing
// trim and end-of-record flushing. Then random well-formed records with noise
// follow. Every character on m_axis is checked field by field against a
// bench-side tokenizer. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module text_word_tokenizer_top_test;

	import twt_pkg::*;

	localparam int          WORD_LIMIT      = WORD_BUFFER_DEF - 1;
	localparam int          PROBE_ROWS      = 25;
	localparam int unsigned RANDOM_ITEMS    = 320;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned GAP_MAX         = 6;
	localparam int unsigned DRAIN_LIMIT     = 20000;
	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned RUN_LIMIT       = 4000000;

	// One emitted character as seen on m_axis
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		logic [NUM_W-1:0]  num;
		logic              eow;
	} char_beat_t;

	// Directed stimulus row; want is used only where typed is set
	typedef struct packed {
		logic [7:0] b;
		logic       eos;
		logic       typed;
		char_beat_t want;
	} probe_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tlast  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	// Bench-side tokenizer state
	mode_t                  scan_st;
	logic                   html_rec;
	logic [7:0]             word_buf [WORD_BUFFER_DEF];
	int unsigned            buf_len;
	logic [NUM_W-1:0]       next_word_num;

	char_beat_t             expected_chars [$];
	logic [7:0]             record_bytes [$];
	probe_row_t             probe_rows [PROBE_ROWS];

	int unsigned            cycle_count      = 0;
	int unsigned            mismatches       = 0;
	int unsigned            bytes_fed        = 0;
	int unsigned            records_fed      = 0;
	int unsigned            chars_checked    = 0;
	int unsigned            full_store_words = 0;
	int unsigned            saturated_words  = 0;
	int unsigned            burst_left       = 0;
	bit                     hold_off_req     = 1'b0;

	text_word_tokenizer_top #(
		.WORD_BUFFER(WORD_BUFFER_DEF)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] byte_value
		.s_axis_tlast  (s_axis_tlast),   // end_of_stream
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [7:0] char_value, [12:8] char_index,
		                                 // [28:13] word_number
		.m_axis_tlast  (m_axis_tlast)    // end_of_word
	);

	// Free-running clock
	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run
	initial begin
		while (cycle_count < RUN_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tokenizer prediction
	// ------------------------------------------------------------------

	function automatic char_class_t byte_kind(input logic [7:0] b);
		char_class_t kind;
		kind = '0;
		case (b)
			CH_SPACE, CH_TAB, CH_NL: begin
				kind.white = 1'b1;
				kind.delim = 1'b1;
			end
			CH_DASH: begin
				kind.punct = 1'b1;
			end
			CH_DOT, CH_COMMA, CH_QMARK, CH_COLON, CH_SEMI, CH_EXCL, CH_LT, CH_GT,
			CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_LBRK, CH_RBRK, CH_PLUS,
			CH_AMP, CH_APOS, CH_QUOTE, CH_SLASH: begin
				kind.punct = 1'b1;
				kind.delim = 1'b1;
			end
			default: begin
			end
		endcase
		return kind;
	endfunction

	function automatic void reset_tokenizer();
		scan_st       = MODE_DETECT;
		html_rec      = 1'b0;
		buf_len       = 0;
		next_word_num = '0;
	endfunction

	// Append one character; report a full store
	function automatic bit append_char(input logic [7:0] b);
		if (buf_len < WORD_LIMIT) begin
			word_buf[buf_len] = b;
			buf_len++;
		end
		return buf_len >= WORD_LIMIT;
	endfunction

	// Trim trailing punctuation and queue the word's characters
	function automatic int emit_word();
		int unsigned      n;
		logic [NUM_W-1:0] num;
		char_class_t      tail_kind;
		n = buf_len;
		while (n > 0) begin
			tail_kind = byte_kind(word_buf[n-1]);
			if (!tail_kind.punct)
				break;
			n--;
		end
		buf_len = 0;
		if (n == 0)
			return 0;
		num = next_word_num;
		if (next_word_num != NUM_MAX)
			next_word_num++;
		if (num == NUM_MAX)
			saturated_words++;
		for (int unsigned k = 0; k < n; k++) begin
			expected_chars.push_back('{ch: word_buf[k], idx: 5'(k), num: num,
				eow: (k + 1 == n)});
		end
		return int'(n);
	endfunction

	// Advance the tokenizer by one byte; return the characters it emitted
	function automatic int tokenize_step(input logic [7:0] b, input logic eos);
		char_class_t kind;
		int          produced;
		kind     = byte_kind(b);
		produced = 0;
		if (scan_st == MODE_DETECT && !kind.white) begin
			html_rec = (b == CH_LT);
			scan_st  = MODE_SKIP;
		end
		case (scan_st)
			MODE_SKIP: begin
				if (html_rec && b == CH_LT) begin
					scan_st = MODE_TAG;
				end else if (!kind.white && !kind.punct) begin
					buf_len = 0;
					if (append_char(b)) begin
						full_store_words++;
						produced = emit_word();
					end else begin
						scan_st = MODE_WORD;
					end
				end
			end
			MODE_TAG: begin
				if (b == CH_GT)
					scan_st = MODE_SKIP;
				else if (b == CH_QUOTE)
					scan_st = MODE_QUOTE;
			end
			MODE_QUOTE: begin
				if (b == CH_QUOTE)
					scan_st = MODE_TAG;
			end
			MODE_WORD: begin
				if (kind.white || kind.delim) begin
					produced = emit_word();
					scan_st  = MODE_SKIP;
				end else if (append_char(b)) begin
					full_store_words++;
					produced = emit_word();
					scan_st  = MODE_SKIP;
				end
			end
			default: begin
			end
		endcase
		// End of record: flush any open word and restart
		if (eos) begin
			if (scan_st == MODE_WORD && produced == 0)
				produced = emit_word();
			reset_tokenizer();
		end
		return produced;
	endfunction

	// ------------------------------------------------------------------
	// Random record generation
	// ------------------------------------------------------------------

	function automatic logic [7:0] word_char_pick();
		logic [7:0]  c;
		char_class_t kind;
		do begin
			c    = 8'($urandom_range(0, 255));
			kind = byte_kind(c);
		end while (kind.white || kind.punct);
		return c;
	endfunction

	// Whitespace sits at indexes 0..2, punctuation after it
	function automatic logic [7:0] gap_byte_pick(input int unsigned top);
		logic [7:0] c;
		case ($urandom_range(0, top))
			0:       c = CH_SPACE;
			1:       c = CH_TAB;
			2:       c = CH_NL;
			3:       c = CH_DOT;
			4:       c = CH_COMMA;
			5:       c = CH_QMARK;
			6:       c = CH_COLON;
			7:       c = CH_SEMI;
			8:       c = CH_EXCL;
			9:       c = CH_LT;
			10:      c = CH_GT;
			11:      c = CH_LPAR;
			12:      c = CH_RPAR;
			13:      c = CH_LBRACE;
			14:      c = CH_RBRACE;
			15:      c = CH_LBRK;
			16:      c = CH_RBRK;
			17:      c = CH_PLUS;
			18:      c = CH_DASH;
			19:      c = CH_AMP;
			20:      c = CH_APOS;
			21:      c = CH_QUOTE;
			default: c = CH_SLASH;
		endcase
		return c;
	endfunction

	function automatic void add_separator();
		repeat ($urandom_range(1, 3))
			record_bytes.push_back(gap_byte_pick(22));
	endfunction

	// Tag with optional quoted parts that may hide '>' and '<'
	function automatic void add_tag();
		record_bytes.push_back(CH_LT);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 3))
				0: record_bytes.push_back(CH_SPACE);
				1: begin
					record_bytes.push_back(CH_QUOTE);
					repeat ($urandom_range(0, 3)) begin
						case ($urandom_range(0, 2))
							0:       record_bytes.push_back(CH_GT);
							1:       record_bytes.push_back(CH_LT);
							default: record_bytes.push_back(word_char_pick());
						endcase
					end
					record_bytes.push_back(CH_QUOTE);
				end
				default: record_bytes.push_back(word_char_pick());
			endcase
		end
		record_bytes.push_back(CH_GT);
	endfunction

	function automatic void build_record();
		bit          html;
		int unsigned len;
		record_bytes.delete();
		html = ($urandom_range(0, 3) == 0);
		repeat ($urandom_range(0, 2))
			record_bytes.push_back(gap_byte_pick(2));
		if (html)
			add_tag();
		repeat ($urandom_range(3, 12)) begin
			case ($urandom_range(0, 9))
				0: record_bytes.push_back(8'($urandom_range(0, 255)));
				1, 2: begin
					if (html)
						add_tag();
					else
						add_separator();
				end
				3: add_separator();
				default: begin
					// Mostly short words, now and then a long one of 28 to 40 bytes that may pass the store size
					len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40)
					                                   : $urandom_range(1, 8);
					record_bytes.push_back(word_char_pick());
					for (int unsigned i = 1; i < len; i++) begin
						if ($urandom_range(0, 7) == 0)
							record_bytes.push_back(CH_DASH);
						else
							record_bytes.push_back(word_char_pick());
					end
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 2))
							record_bytes.push_back(CH_DASH);
					end
					add_separator();
				end
			endcase
		end
		// Cut some records short so the end lands in any mode
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(1, record_bytes.size());
			while (record_bytes.size() > len)
				void'(record_bytes.pop_back());
		end
		if (record_bytes.size() == 0)
			record_bytes.push_back(word_char_pick());
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte in bursts with random gaps, then predict at acceptance
	task automatic feed_byte(input logic [7:0] b, input logic eos, input logic typed,
		input char_beat_t want);
		int unsigned gap;
		int unsigned mark;
		if (burst_left == 0) begin
			gap = $urandom_range(0, GAP_MAX);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		mark = expected_chars.size();
		void'(tokenize_step(b, eos));
		if (typed) begin
			while (expected_chars.size() > mark)
				void'(expected_chars.pop_back());
			expected_chars.push_back(want);
		end
		bytes_fed++;
		if (eos)
			records_fed++;
	endtask

	task automatic run_random_records(input int unsigned quota);
		int unsigned sent;
		sent = 0;
		while (sent < quota) begin
			build_record();
			foreach (record_bytes[i])
				feed_byte(record_bytes[i], i == record_bytes.size() - 1, 1'b0, '0);
			sent += record_bytes.size();
		end
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Stall on a random pattern that is redrawn when the slot counter wraps; honor a hold-off request
	initial begin
		logic [31:0] pattern;
		int unsigned slot;
		int unsigned hold;
		pattern = '1;
		slot    = 0;
		hold    = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold         = HOLD_OFF_CYCLES;
			end
			if (slot == 0) begin
				case ($urandom_range(0, 3))
					0:       pattern = '1;
					1:       pattern = $urandom;
					2:       pattern = $urandom | $urandom;
					default: pattern = $urandom & $urandom;
				endcase
			end
			slot = (slot + 1) % 32;
			if (hold != 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= pattern[0];
				pattern = {pattern[0], pattern[31:1]};
			end
		end
	end

	// Compare each character transaction with the oldest expectation
	always @(negedge clk) begin
		char_beat_t got;
		char_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{ch: m_axis_tdata[7:0], idx: m_axis_tdata[12:8],
				num: m_axis_tdata[28:13], eow: m_axis_tlast};
			chars_checked++;
			if (expected_chars.size() == 0) begin
				$error("unexpected character %02h index %0d word %0d", got.ch, got.idx,
					got.num);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (got.ch != want.ch) begin
					$error("char_value: expected %02h, got %02h", want.ch, got.ch);
					mismatches++;
				end
				if (got.idx != want.idx) begin
					$error("char_index: expected %0d, got %0d", want.idx, got.idx);
					mismatches++;
				end
				if (got.num != want.num) begin
					$error("word_number: expected %0d, got %0d", want.num, got.num);
					mismatches++;
				end
				if (got.eow != want.eow) begin
					$error("end_of_word: expected %0d, got %0d", want.eow, got.eow);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int unsigned drain_wait;
		reset_tokenizer();
		probe_rows = '{
			// Plain record: leading whitespace, extreme bytes, trailing dash trim
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{CH_TAB,   1'b0, 1'b0, '0},
			'{8'hFF,    1'b0, 1'b0, '0},
			'{CH_COMMA, 1'b0, 1'b1, '{8'hFF, 5'd0, 16'd0, 1'b1}},
			'{8'h00,    1'b0, 1'b0, '0},
			'{CH_DASH,  1'b0, 1'b0, '0},
			'{CH_NL,    1'b0, 1'b1, '{8'h00, 5'd0, 16'd1, 1'b1}},
			'{"b",      1'b0, 1'b0, '0},
			'{CH_LT,    1'b0, 1'b1, '{"b", 5'd0, 16'd2, 1'b1}},
			'{CH_GT,    1'b0, 1'b0, '0},
			'{"c",      1'b0, 1'b0, '0},
			'{"d",      1'b1, 1'b0, '0},
			// HTML record: tag opened by the detect byte, quoted '>' in a tag,
			// and a '<' that only ends a word
			'{CH_SPACE, 1'b0, 1'b0, '0},
			'{CH_LT,    1'b0, 1'b0, '0},
			'{"p",      1'b0, 1'b0, '0},
			'{CH_QUOTE, 1'b0, 1'b0, '0},
			'{CH_GT,    1'b0, 1'b0, '0},
			'{CH_QUOTE, 1'b0, 1'b0, '0},
			'{CH_GT,    1'b0, 1'b0, '0},
			'{"h",      1'b0, 1'b0, '0},
			'{"i",      1'b0, 1'b0, '0},
			'{CH_LT,    1'b0, 1'b0, '0},
			'{"x",      1'b1, 1'b1, '{"x", 5'd0, 16'd1, 1'b1}},
			// End of record inside an open tag drops the bytes
			'{CH_LT,    1'b0, 1'b0, '0},
			'{"a",      1'b1, 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i])
			feed_byte(probe_rows[i].b, probe_rows[i].eos, probe_rows[i].typed,
				probe_rows[i].want);

		// Back up the whole pipe while the sender keeps offering
		hold_off_req = 1'b1;
		run_random_records(RANDOM_ITEMS / 2);

		run_random_records(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		s_axis_tvalid <= 1'b0;

		// Drain, then watch for stray characters
		drain_wait = 0;
		while (expected_chars.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
			mismatches++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Fed %0d bytes in %0d records; checked %0d characters.",
			bytes_fed, records_fed, chars_checked);
		$display("Full-store words: %0d; words at the saturated number: %0d.",
			full_store_words, saturated_words);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
